### rtl/core/npr_pkg.sv
// Shared types, widths and register codes for the nearest-point-to-ray unit.
`timescale 1ns / 1ps
`default_nettype none

package npr_pkg;

  // Field widths of the point, direction, distance and result formats.
  localparam int COORD_W     = 24;
  localparam int DIR_W       = 16;
  localparam int DIST_W      = 52;
  localparam int IDX_OUT_W   = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 52;

  // Internal arithmetic widths.
  localparam int VEC_W       = COORD_W + 1;        // p - o
  localparam int PROD_W      = VEC_W + DIR_W;      // (p - o) * d
  localparam int CROSS_W     = PROD_W + 1;         // difference of two products
  localparam int FRAC_SHIFT  = 14;                 // Q.26 down to Q.12
  localparam int RC_W        = CROSS_W - FRAC_SHIFT;
  localparam int MAG_W       = RC_W - 1;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = SQ_W + 2;

  // Defaults for the top-level parameters.
  localparam int MAX_POINTS_DEF = 1048576;
  localparam int QUEUE_DEPTH    = 4;

  // Reset values of the configuration registers.
  localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 16'sd16384;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIR_X       = 3'd3,
    REG_DIR_Y       = 3'd4,
    REG_DIR_Z       = 3'd5,
    REG_MIN_DIST_SQ = 3'd6
  } cfg_reg_t;

  // Ray and threshold as held by the register bank.
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
    logic [DIST_W-1:0]         min_dist_sq;
  } ray_cfg_t;

  // Per-point control sideband decided by the front end.
  typedef struct packed {
    logic counted;   // point takes part in the argmin
    logic last;      // point closes the cloud
  } point_tag_t;

  // One classified point as it waits in the queue.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    point_tag_t                tag;
  } point_t;

endpackage

`default_nettype wire

### rtl/core/npr_if.sv
// Channel interfaces for points, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface npr_point_if;
  import npr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic                      last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface npr_result_if;
  import npr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [IDX_OUT_W-1:0] picked_index;
  logic [DIST_W-1:0]    best_dist_sq;
  modport source (output valid, hit, picked_index, best_dist_sq, input ready);
  modport sink   (input valid, hit, picked_index, best_dist_sq, output ready);
endinterface

interface npr_cfg_if;
  import npr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/nearest_point_to_ray_unit.sv
// Top level: register bank and the front, queue and back sections of the unit.
// Path: a point that closes a cloud goes through the queue into the first of five distance
// stages, four more distance stages, and the compare-and-keep into the result register.
// Throughput: one point per cycle; the five distance stages and the compare-and-keep each
// take a new point every cycle, and the pipeline halts only while a result waits at the
// output. Configuration writes are always accepted.
// Reset (rst_n low, synchronous) empties the queue and the pipeline, clears the point
// count and running best, and loads the registers with origin 0, direction +z, threshold 0.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_to_ray_unit #(
  parameter int MAX_POINTS  = npr_pkg::MAX_POINTS_DEF,
  parameter int QUEUE_DEPTH = npr_pkg::QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  npr_point_if.sink     in_chan,
  npr_result_if.source  out_chan,
  npr_cfg_if.sink       cfg_chan
);
  import npr_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  ray_cfg_t cfg_r;

  // Register bank: writes are always taken, unknown indexes are dropped.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.origin_z    <= '0;
      cfg_r.dir_x       <= '0;
      cfg_r.dir_y       <= '0;
      cfg_r.dir_z       <= DIR_Z_RESET;
      cfg_r.min_dist_sq <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_ORIGIN_X:    cfg_r.origin_x    <= cfg_chan.data[COORD_W-1:0];
        REG_ORIGIN_Y:    cfg_r.origin_y    <= cfg_chan.data[COORD_W-1:0];
        REG_ORIGIN_Z:    cfg_r.origin_z    <= cfg_chan.data[COORD_W-1:0];
        REG_DIR_X:       cfg_r.dir_x       <= cfg_chan.data[DIR_W-1:0];
        REG_DIR_Y:       cfg_r.dir_y       <= cfg_chan.data[DIR_W-1:0];
        REG_DIR_Z:       cfg_r.dir_z       <= cfg_chan.data[DIR_W-1:0];
        REG_MIN_DIST_SQ: cfg_r.min_dist_sq <= cfg_chan.data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end to queue.
  logic             push;
  point_t           push_point;
  logic [IDX_W-1:0] push_idx;
  logic             q_full;

  npr_front #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .q_full     (q_full),
    .push       (push),
    .push_point (push_point),
    .push_idx   (push_idx)
  );

  // Queue to back end.
  logic             pop;
  logic             q_valid;
  point_t           q_point;
  logic [IDX_W-1:0] q_idx;

  npr_queue #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_point (push_point),
    .push_idx   (push_idx),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_point    (q_point),
    .q_idx      (q_idx)
  );

  npr_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_point  (q_point),
    .q_idx    (q_idx),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

### rtl/core/npr_front.sv
// Front end: accepts points, counts them and tags each one for the back end.
`timescale 1ns / 1ps
`default_nettype none

module npr_front #(
  parameter int MAX_POINTS = npr_pkg::MAX_POINTS_DEF,
  parameter int IDX_W      = 20,
  parameter int CNT_W      = 21
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  npr_point_if.sink           in_chan,
  input  wire logic           q_full,
  output logic                push,
  output npr_pkg::point_t     push_point,
  output logic [IDX_W-1:0]    push_idx
);
  import npr_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             counted;

  // The queue has room: take the transaction.
  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  // Points beyond the capacity are passed on but left out of the argmin.
  assign counted = count_r < CNT_W'(MAX_POINTS);

  always_comb begin
    push_point.x           = in_chan.point_x;
    push_point.y           = in_chan.point_y;
    push_point.z           = in_chan.point_z;
    push_point.tag.counted = counted;
    push_point.tag.last    = in_chan.last_point;
    push_idx               = count_r[IDX_W-1:0];
  end

  // Arrival counter, cleared by the last point of each cloud.
  always_comb begin
    count_nxt = count_r;
    if (push) begin
      if (in_chan.last_point) begin
        count_nxt = '0;
      end else if (counted) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/npr_queue.sv
// Small FIFO that decouples the front end from the distance pipeline.
`timescale 1ns / 1ps
`default_nettype none

module npr_queue #(
  parameter int DEPTH = npr_pkg::QUEUE_DEPTH,
  parameter int IDX_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire npr_pkg::point_t  push_point,
  input  wire logic [IDX_W-1:0] push_idx,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output npr_pkg::point_t       q_point,
  output logic [IDX_W-1:0]      q_idx
);
  import npr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  point_t           pt_mem [DEPTH];
  logic [IDX_W-1:0] idx_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_point = pt_mem[rd_ptr_r];
  assign q_idx   = idx_mem[rd_ptr_r];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      pt_mem[wr_ptr_r]  <= push_point;
      idx_mem[wr_ptr_r] <= push_idx;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != CNT_W'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue read while empty");

endmodule

`default_nettype wire

### rtl/core/npr_back.sv
// Back end: distance pipeline, compare-and-keep of the best point, result register.
`timescale 1ns / 1ps
`default_nettype none

module npr_back #(
  parameter int IDX_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire npr_pkg::ray_cfg_t cfg,
  input  wire logic             q_valid,
  input  wire npr_pkg::point_t  q_point,
  input  wire logic [IDX_W-1:0] q_idx,
  output logic                  pop,
  npr_result_if.source          out_chan
);
  import npr_pkg::*;

  localparam logic [CROSS_W-1:0] RND = CROSS_W'(1) << (FRAC_SHIFT - 1);
  localparam logic [DIST_W-1:0]  DIST_MAX = '1;

  // Whole pipeline moves unless a finished result is still waiting.
  logic adv;
  assign adv = !out_chan.valid || out_chan.ready;
  assign pop = adv && q_valid;

  // Stage valid bits and sideband.
  logic             s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  point_tag_t       s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r, s5_tag_r;
  logic [IDX_W-1:0] s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r;

  // Stage payloads.
  logic signed [VEC_W-1:0]  s1_vx_r, s1_vy_r, s1_vz_r;
  logic signed [PROD_W-1:0] s2_yz_r, s2_zy_r, s2_zx_r, s2_xz_r, s2_xy_r, s2_yx_r;
  logic signed [RC_W-1:0]   s3_cx_r, s3_cy_r, s3_cz_r;
  logic [SQ_W-1:0]          s4_sx_r, s4_sy_r, s4_sz_r;
  logic [DIST_W-1:0]        s5_dist_r;

  // Combinational helpers per stage.
  logic signed [CROSS_W-1:0] cross_x, cross_y, cross_z;
  logic [MAG_W-1:0]          mag_x, mag_y, mag_z;
  logic [SUM_W-1:0]          sq_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r <= q_point.tag;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
      s4_tag_r <= s3_tag_r;
      s5_tag_r <= s4_tag_r;
      s1_idx_r <= q_idx;
      s2_idx_r <= s1_idx_r;
      s3_idx_r <= s2_idx_r;
      s4_idx_r <= s3_idx_r;
      s5_idx_r <= s4_idx_r;
    end
  end

  // Stage 1: offset of the point from the ray origin.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vx_r <= VEC_W'(q_point.x) - VEC_W'(cfg.origin_x);
      s1_vy_r <= VEC_W'(q_point.y) - VEC_W'(cfg.origin_y);
      s1_vz_r <= VEC_W'(q_point.z) - VEC_W'(cfg.origin_z);
    end
  end

  // Stage 2: the six partial products of the cross product.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_yz_r <= s1_vy_r * cfg.dir_z;
      s2_zy_r <= s1_vz_r * cfg.dir_y;
      s2_zx_r <= s1_vz_r * cfg.dir_x;
      s2_xz_r <= s1_vx_r * cfg.dir_z;
      s2_xy_r <= s1_vx_r * cfg.dir_y;
      s2_yx_r <= s1_vy_r * cfg.dir_x;
    end
  end

  // Stage 3: cross components, rounded half up from Q.26 to Q.12.
  always_comb begin
    cross_x = CROSS_W'(s2_yz_r) - CROSS_W'(s2_zy_r) + $signed(RND);
    cross_y = CROSS_W'(s2_zx_r) - CROSS_W'(s2_xz_r) + $signed(RND);
    cross_z = CROSS_W'(s2_xy_r) - CROSS_W'(s2_yx_r) + $signed(RND);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cx_r <= cross_x[CROSS_W-1:FRAC_SHIFT];
      s3_cy_r <= cross_y[CROSS_W-1:FRAC_SHIFT];
      s3_cz_r <= cross_z[CROSS_W-1:FRAC_SHIFT];
    end
  end

  // Stage 4: square the magnitude of each component.
  always_comb begin
    mag_x = s3_cx_r[RC_W-1] ? MAG_W'(-s3_cx_r) : MAG_W'(s3_cx_r);
    mag_y = s3_cy_r[RC_W-1] ? MAG_W'(-s3_cy_r) : MAG_W'(s3_cy_r);
    mag_z = s3_cz_r[RC_W-1] ? MAG_W'(-s3_cz_r) : MAG_W'(s3_cz_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sx_r <= SQ_W'(mag_x) * SQ_W'(mag_x);
      s4_sy_r <= SQ_W'(mag_y) * SQ_W'(mag_y);
      s4_sz_r <= SQ_W'(mag_z) * SQ_W'(mag_z);
    end
  end

  // Stage 5: sum of squares, saturated to the distance width.
  assign sq_sum = SUM_W'(s4_sx_r) + SUM_W'(s4_sy_r) + SUM_W'(s4_sz_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_dist_r <= (|sq_sum[SUM_W-1:DIST_W]) ? DIST_MAX : sq_sum[DIST_W-1:0];
    end
  end

  // Stage 6: compare-and-keep of the running best, result on the last point.
  logic [DIST_W-1:0] best_sq_r, best_sq_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic              any_seen_r, any_seen_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic              res_hit_r;
  logic [IDX_W-1:0]  res_idx_r;
  logic [DIST_W-1:0] res_dist_r;

  logic              keep_fire;
  logic              better;
  logic [DIST_W-1:0] best_sq_upd;
  logic [IDX_W-1:0]  best_idx_upd;
  logic              any_seen_upd;
  logic              hit_upd;

  assign keep_fire = adv && s5_valid_r;

  // Both threshold compares run side by side so only a select follows them.
  always_comb begin
    better       = s5_tag_r.counted && (s5_dist_r < best_sq_r);
    best_sq_upd  = better ? s5_dist_r : best_sq_r;
    best_idx_upd = better ? s5_idx_r : best_idx_r;
    any_seen_upd = any_seen_r || s5_tag_r.counted;
    hit_upd      = any_seen_upd &&
                   (better ? (s5_dist_r < cfg.min_dist_sq) : (best_sq_r < cfg.min_dist_sq));
  end

  always_comb begin
    best_sq_nxt   = best_sq_r;
    best_idx_nxt  = best_idx_r;
    any_seen_nxt  = any_seen_r;
    res_valid_nxt = res_valid_r;
    if (adv) begin
      res_valid_nxt = keep_fire && s5_tag_r.last;
    end
    if (keep_fire) begin
      if (s5_tag_r.last) begin
        best_sq_nxt  = DIST_MAX;
        best_idx_nxt = '0;
        any_seen_nxt = 1'b0;
      end else begin
        best_sq_nxt  = best_sq_upd;
        best_idx_nxt = best_idx_upd;
        any_seen_nxt = any_seen_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_sq_r   <= DIST_MAX;
      best_idx_r  <= '0;
      any_seen_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      best_sq_r   <= best_sq_nxt;
      best_idx_r  <= best_idx_nxt;
      any_seen_r  <= any_seen_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Result register, loaded when the last point of a cloud is resolved.
  always_ff @(posedge clk) begin
    if (keep_fire && s5_tag_r.last) begin
      res_hit_r  <= hit_upd;
      res_idx_r  <= hit_upd ? best_idx_upd : '0;
      res_dist_r <= best_sq_upd;
    end
  end

  assign out_chan.valid        = res_valid_r;
  assign out_chan.hit          = res_hit_r;
  assign out_chan.picked_index = IDX_OUT_W'(res_idx_r);
  assign out_chan.best_dist_sq = res_dist_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (keep_fire && s5_tag_r.last) |=> (best_sq_r == DIST_MAX && !any_seen_r && best_idx_r == '0))
    else $error("running best not cleared after the last point");

  a_empty_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    !any_seen_r |-> (best_sq_r == DIST_MAX))
    else $error("best distance set with no point seen");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_chan.ready) |-> !pop)
    else $error("pipeline advanced over a pending result");

endmodule

`default_nettype wire

### sim/npr_checker.sv
// Checker for the nearest-point-to-ray unit: tracks the ray, predicts each pick and compares results.
`timescale 1ns / 1ps

module npr_checker
  import npr_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  npr_point_if  pts,
  npr_result_if res,
  npr_cfg_if    cfg,
  output int    fail_count,
  output int    outstanding
);

  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  // One predicted pick, in the order the clouds close.
  typedef struct {
    logic                 hit;
    logic [IDX_OUT_W-1:0] idx;
    logic [DIST_W-1:0]    dist_sq;
  } pick_t;

  pick_t picks_due[$];

  // Shadow copy of the ray and threshold.
  logic signed [COORD_W-1:0] org_x, org_y, org_z;
  logic signed [DIR_W-1:0]   dir_x, dir_y, dir_z;
  logic [DIST_W-1:0]         thr;

  // Running argmin over the current cloud.
  int unsigned       seen_count;
  int unsigned       best_at;
  logic [DIST_W-1:0] best_sq;
  logic              any_point;
  int                errs;

  // Round a Q.26 cross component to Q.12, half up.
  function automatic longint round_to_q12(input longint v);
    return (v + 64'sd8192) >>> FRAC_SHIFT;
  endfunction

  // Squared perpendicular distance |(p - o) x d|^2 in Q28.24, saturated.
  function automatic logic [DIST_W-1:0] ray_dist_sq(input logic signed [COORD_W-1:0] px,
                                                    input logic signed [COORD_W-1:0] py,
                                                    input logic signed [COORD_W-1:0] pz);
    longint vx, vy, vz, dx, dy, dz, cx, cy, cz, total;
    vx = longint'(px) - longint'(org_x);
    vy = longint'(py) - longint'(org_y);
    vz = longint'(pz) - longint'(org_z);
    dx = longint'(dir_x);
    dy = longint'(dir_y);
    dz = longint'(dir_z);
    cx = round_to_q12(vy * dz - vz * dy);
    cy = round_to_q12(vz * dx - vx * dz);
    cz = round_to_q12(vx * dy - vy * dx);
    total = cx * cx + cy * cy + cz * cz;
    if (total > longint'(DIST_SAT)) begin
      return DIST_SAT;
    end
    return total[DIST_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    pick_t             want;
    pick_t             got;
    logic [DIST_W-1:0] d_sq;
    if (!rst_n) begin
      org_x = '0;
      org_y = '0;
      org_z = '0;
      dir_x = '0;
      dir_y = '0;
      dir_z = DIR_Z_RESET;
      thr = '0;
      seen_count = 0;
      best_at = 0;
      best_sq = DIST_SAT;
      any_point = 1'b0;
      picks_due.delete();
    end else begin
      // Register writes; an index past the last register is dropped.
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ORIGIN_X:    org_x = cfg.data[COORD_W-1:0];
          REG_ORIGIN_Y:    org_y = cfg.data[COORD_W-1:0];
          REG_ORIGIN_Z:    org_z = cfg.data[COORD_W-1:0];
          REG_DIR_X:       dir_x = cfg.data[DIR_W-1:0];
          REG_DIR_Y:       dir_y = cfg.data[DIR_W-1:0];
          REG_DIR_Z:       dir_z = cfg.data[DIR_W-1:0];
          REG_MIN_DIST_SQ: thr = cfg.data[DIST_W-1:0];
          default: ;
        endcase
      end

      // Point transaction: points past the cap are neither compared nor counted.
      if (pts.valid && pts.ready) begin
        if (seen_count < MAX_POINTS) begin
          d_sq = ray_dist_sq(pts.point_x, pts.point_y, pts.point_z);
          if (d_sq < best_sq) begin
            best_sq = d_sq;
            best_at = seen_count;
          end
          any_point = 1'b1;
          seen_count++;
        end
        if (pts.last_point) begin
          want.hit = any_point && (best_sq < thr);
          want.idx = want.hit ? best_at[IDX_OUT_W-1:0] : '0;
          want.dist_sq = best_sq;
          picks_due.push_back(want);
          seen_count = 0;
          best_at = 0;
          best_sq = DIST_SAT;
          any_point = 1'b0;
        end
      end

      // Result transaction against the oldest prediction.
      if (res.valid && res.ready) begin
        got.hit = res.hit;
        got.idx = res.picked_index;
        got.dist_sq = res.best_dist_sq;
        if (picks_due.size() == 0) begin
          $error("result with no pick pending: hit %0d, picked_index %0d, best_dist_sq %0d",
                 got.hit, got.idx, got.dist_sq);
          errs++;
        end else begin
          want = picks_due.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            errs++;
          end
          if (got.idx !== want.idx) begin
            $error("picked_index: expected %0d, actual %0d", want.idx, got.idx);
            errs++;
          end
          if (got.dist_sq !== want.dist_sq) begin
            $error("best_dist_sq: expected %0d, actual %0d", want.dist_sq, got.dist_sq);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    outstanding <= picks_due.size();
  end

endmodule

### sim/nearest_point_to_ray_unit_tb.sv
// Testbench top: clock, reset, point and register stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module nearest_point_to_ray_unit_tb;
  import npr_pkg::*;

  localparam int MAX_PTS        = 48;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 75;
  localparam int PRESSURE_PHASE = 4;

  // Index past the last register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7fffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
  localparam logic [DIST_W-1:0]         DIST_MAX  = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  npr_point_if  pt_if ();
  npr_result_if res_if ();
  npr_cfg_if    cfg_if ();

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_req;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   outstanding;

  // Current ray, kept for aiming points near it.
  longint ray_o[3];
  longint ray_d[3];

  nearest_point_to_ray_unit #(
    .MAX_POINTS(MAX_PTS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (pt_if),
    .out_chan(res_if),
    .cfg_chan(cfg_if)
  );

  npr_checker #(
    .MAX_POINTS(MAX_PTS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pts        (pt_if),
    .res        (res_if),
    .cfg        (cfg_if),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      res_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [COORD_W-1:0] random_coord();
    logic [31:0] r;
    r = $urandom();
    return r[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) begin
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  // One register transaction; valid stays up when another write follows.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                           input bit keep_valid);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (!keep_valid) begin
      cfg_if.valid <= 1'b0;
    end
  endtask

  // Load the whole ray; unused upper data bits carry junk that must be ignored.
  task automatic set_ray(input longint ox, input longint oy, input longint oz,
                         input longint dx, input longint dy, input longint dz,
                         input logic [DIST_W-1:0] thr, input bit poke_unused);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    write_reg(REG_ORIGIN_X, {junk[51:24], ox[23:0]}, 1'b1);
    write_reg(REG_ORIGIN_Y, {junk[50:23], oy[23:0]}, 1'b1);
    write_reg(REG_ORIGIN_Z, {junk[49:22], oz[23:0]}, 1'b1);
    write_reg(REG_DIR_X, {junk[51:16], dx[15:0]}, 1'b1);
    write_reg(REG_DIR_Y, {junk[50:15], dy[15:0]}, 1'b1);
    write_reg(REG_DIR_Z, {junk[49:14], dz[15:0]}, 1'b1);
    if (poke_unused) begin
      write_reg(REG_UNUSED, junk[51:0], 1'b1);
    end
    write_reg(REG_MIN_DIST_SQ, thr, 1'b0);
    ray_o = '{ox, oy, oz};
    ray_d = '{dx, dy, dz};
  endtask

  task automatic pick_random_ray(input bit poke_unused);
    longint              o[3];
    longint              d[3];
    logic [DIST_W-1:0]   thr;
    logic signed [15:0]  dr;
    logic [63:0]         wide;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(3) == 0) begin
        o[i] = longint'(random_coord());
      end else begin
        o[i] = longint'($urandom_range(0, 2097152)) - 1048576;
      end
    end
    case ($urandom_range(5))
      0: d = '{0, 0, 16384};
      1: d = '{16384, 0, 0};
      2: d = '{0, -16384, 0};
      3: d = '{11585, 0, -11585};
      4: begin
        for (int i = 0; i < 3; i++) begin
          dr = 16'($urandom());
          d[i] = longint'(dr);
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          d[i] = longint'($urandom_range(0, 6)) - 3;
        end
      end
    endcase
    wide = {$urandom(), $urandom()};
    case ($urandom_range(7))
      0:       thr = '0;
      1:       thr = DIST_MAX;
      2:       thr = wide[DIST_W-1:0];
      default: thr = DIST_W'($urandom_range(0, 1 << 22));
    endcase
    set_ray(o[0], o[1], o[2], d[0], d[1], d[2], thr, poke_unused);
  endtask

  // One point transaction, preceded by random sender idling.
  task automatic send_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z, input bit is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      pt_if.valid <= 1'b0;
      @(posedge clk);
    end
    pt_if.valid <= 1'b1;
    pt_if.point_x <= x;
    pt_if.point_y <= y;
    pt_if.point_z <= z;
    pt_if.last_point <= is_last;
    @(posedge clk);
    while (!pt_if.ready) @(posedge clk);
  endtask

  // Let every pick come out and the pipeline empty before touching registers.
  task automatic settle();
    pt_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                        sent;
    int                        n;
    int                        r;
    int                        s;
    longint                    t;
    longint                    noise;
    logic signed [COORD_W-1:0] p[3];

    pt_if.valid <= 1'b0;
    pt_if.point_x <= '0;
    pt_if.point_y <= '0;
    pt_if.point_z <= '0;
    pt_if.last_point <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_ORIGIN_X;
    cfg_if.data <= '0;
    hold_req <= 1'b0;
    ray_o = '{0, 0, 0};
    ray_d = '{0, 0, 16384};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset ray and zero threshold: every cloud misses.
    send_point('0, '0, '0, 1'b1);
    send_point(COORD_MAX, COORD_MIN, '0, 1'b0);
    send_point(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
    send_point('0, '0, COORD_MIN, 1'b0);
    send_point('1, '1, '1, 1'b1);
    settle();

    // Oversized direction so the distance saturates and never takes the best.
    set_ray(longint'(COORD_MIN), longint'(COORD_MAX), longint'(COORD_MAX),
            -32768, 32767, -32768, DIST_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
    send_point(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
    settle();

    // Zero direction: every point at distance zero, the first one wins.
    set_ray(0, 0, 0, 0, 0, 0, 52'd1, 1'b1);
    send_point(24'sd123, -24'sd456, 24'sd789, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    settle();

    // Equal distances, with the threshold at and just above them.
    set_ray(0, 0, 0, 0, 0, 16384, 52'd16777216, 1'b0);
    send_point(24'sd4096, '0, 24'sd5, 1'b0);
    send_point('0, -24'sd4096, 24'sd9, 1'b0);
    send_point(-24'sd4096, '0, '0, 1'b1);
    settle();
    write_reg(REG_UNUSED, '1, 1'b1);
    write_reg(REG_MIN_DIST_SQ, 52'd16777217, 1'b0);
    send_point(24'sd4096, '0, 24'sd5, 1'b0);
    send_point('0, -24'sd4096, 24'sd9, 1'b0);
    send_point(-24'sd4096, '0, '0, 1'b0);
    send_point('0, 24'sd4095, '0, 1'b1);
    settle();

    // Tiny direction: cross terms land on the rounding boundary.
    set_ray(0, 0, 0, 0, 0, 1, 52'd2, 1'b0);
    send_point(-24'sd8192, '0, '0, 1'b0);
    send_point(24'sd8193, '0, '0, 1'b0);
    send_point(24'sd8192, '0, '0, 1'b1);
    settle();

    // Random phases with varied rays and traffic patterns.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 64;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 64;
        end
        default: begin
          tx_idle_pct = 24;
          rx_stall_pct = 24;
        end
      endcase
      pick_random_ray(phase % 3 == 0);
      if (phase == PRESSURE_PHASE) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly short clouds; now and then one near or past the point cap.
        if ($urandom_range(19) == 0) begin
          n = $urandom_range(MAX_PTS - 2, MAX_PTS + 12);
        end else begin
          n = $urandom_range(1, 10);
        end
        for (int j = 0; j < n; j++) begin
          r = $urandom_range(9);
          if (r <= 5) begin
            // Near the ray, with noise of random scale.
            t = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
            for (int a = 0; a < 3; a++) begin
              s = $urandom_range(12);
              noise = longint'($urandom_range(0, 2 << s)) - (1 << s);
              p[a] = clamp_coord(ray_o[a] + ((t * ray_d[a]) >>> 14) + noise);
            end
          end else if (r == 6 && j > 0) begin
            // Repeat the previous point to force a tie.
          end else if (r == 9) begin
            for (int a = 0; a < 3; a++) begin
              p[a] = extreme_coord();
            end
          end else begin
            for (int a = 0; a < 3; a++) begin
              p[a] = random_coord();
            end
          end
          send_point(p[0], p[1], p[2], j == n - 1);
          if (j < MAX_PTS) begin
            sent++;
          end
        end
      end
      settle();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
